// ----- design/iml_pkg.sv -----
// ----------------------------------------------------------------------------
// iml_pkg: shared types and constants for the image min/max locator
// Field widths, register indexes, result kinds and the structs passed
// between the configuration, front, queue and back parts.
// ----------------------------------------------------------------------------
package iml_pkg;

    localparam int INDEX_BITS  = 24;
    localparam int SAMPLE_BITS = 32;
    localparam int NP_BITS     = INDEX_BITS + 1;   // frame length, up to 2^INDEX_BITS
    localparam int KIND_BITS   = 2;
    localparam int CFG_IDX_BITS = 1;
    localparam int OUT_DATA_BITS = 2 * SAMPLE_BITS + 2 * INDEX_BITS;

    // floor(x/3) = (x * DIV3_MULT) >> DIV3_SHIFT, exact for x < 2^DIV3_SHIFT
    localparam int DIV3_SHIFT = NP_BITS + 2;
    localparam int MULT_BITS  = DIV3_SHIFT - 1;
    localparam logic [MULT_BITS-1:0] DIV3_MULT =
        MULT_BITS'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
    localparam int PROD_BITS  = DIV3_SHIFT + NP_BITS;

    localparam logic [NP_BITS-1:0] NP_MAX = NP_BITS'(64'd1 << INDEX_BITS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_POINTS = 1'b0,
        REG_RGB_MODE   = 1'b1
    } reg_index_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_OVERALL = 2'd0,
        KIND_RED     = 2'd1,
        KIND_GREEN   = 2'd2,
        KIND_BLUE    = 2'd3
    } kind_t;

    // frame geometry derived from the configuration registers
    typedef struct packed {
        logic [NP_BITS-1:0] n;      // effective frame length
        logic [NP_BITS-1:0] b1;     // first green index
        logic [NP_BITS-1:0] b2;     // first blue index
        logic               rgb_mode;
    } bounds_t;

    // classified sample passed from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [INDEX_BITS-1:0]         idx;            // index within frame
        logic [INDEX_BITS-1:0]         rel;            // index within plane
        logic [1:0]                    plane;          // 0 red, 1 green, 2 blue
        logic                          frame_restart;
        logic                          plane_restart;
        logic                          frame_end;
        logic                          emit_plane;
    } item_t;

    typedef struct packed {
        kind_t                         kind;
        logic signed [SAMPLE_BITS-1:0] min_value;
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic [INDEX_BITS-1:0]         min_index;
        logic [INDEX_BITS-1:0]         max_index;
        logic                          last;
    } result_t;

endpackage

// ----- design/iml_cfg.sv -----
// ----------------------------------------------------------------------------
// iml_cfg: configuration registers and plane boundaries
// Holds num_points and the colour mode flag, clamps the frame length and
// derives the plane boundaries n/3 and 2n/3 with a reciprocal multiply.
// ----------------------------------------------------------------------------
module iml_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [iml_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [iml_pkg::NP_BITS-1:0]      cfg_data,
    output iml_pkg::bounds_t                 bounds,
    output logic                             busy
);
    import iml_pkg::*;

    logic [NP_BITS-1:0]   num_points_reg;
    logic                 rgb_mode_reg;
    logic [1:0]           busy_cnt_reg;
    logic [NP_BITS-1:0]   n_eff;
    logic [NP_BITS-1:0]   n_reg;
    logic [PROD_BITS-1:0] prod1_reg, prod1_next;
    logic [PROD_BITS-1:0] prod2_reg, prod2_next;
    logic                 wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= NP_BITS'(1);
            rgb_mode_reg   <= 1'b0;
            busy_cnt_reg   <= 2'd2;
        end else begin
            if (wr) begin
                case (reg_index_t'(cfg_index))
                    REG_NUM_POINTS: num_points_reg <= cfg_data;
                    REG_RGB_MODE:   rgb_mode_reg   <= cfg_data[0];
                    default:        ;
                endcase
                busy_cnt_reg <= 2'd2;
            end else if (busy_cnt_reg != 2'd0) begin
                busy_cnt_reg <= busy_cnt_reg - 2'd1;
            end
        end
    end

    // zero acts as one, anything past 2^INDEX_BITS saturates
    always_comb begin
        if (num_points_reg == '0)
            n_eff = NP_BITS'(1);
        else if (num_points_reg > NP_MAX)
            n_eff = NP_MAX;
        else
            n_eff = num_points_reg;
    end

    assign prod1_next = PROD_BITS'(n_eff) * PROD_BITS'(DIV3_MULT);
    assign prod2_next = PROD_BITS'({n_eff, 1'b0}) * PROD_BITS'(DIV3_MULT);

    always_ff @(posedge aclk) begin
        n_reg     <= n_eff;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
    end

    assign bounds.n        = n_reg;
    assign bounds.b1       = prod1_reg[DIV3_SHIFT +: NP_BITS];
    assign bounds.b2       = prod2_reg[DIV3_SHIFT +: NP_BITS];
    assign bounds.rgb_mode = rgb_mode_reg;
    assign busy            = (busy_cnt_reg != 2'd0);

endmodule

// ----- design/iml_front.sv -----
// ----------------------------------------------------------------------------
// iml_front: sample intake and classification
// Tracks the frame index and current plane, and tags each sample with its
// plane, plane-relative index, restart flags and end-of-scope flags.
// ----------------------------------------------------------------------------
module iml_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  iml_pkg::bounds_t                    bounds,
    input  logic                                accept,
    input  logic signed [iml_pkg::SAMPLE_BITS-1:0] sample,
    output iml_pkg::item_t                      item
);
    import iml_pkg::*;

    logic [INDEX_BITS-1:0] count_reg;
    logic [1:0]            plane_reg;
    logic [NP_BITS-1:0]    cw, c1, ps, pe;
    logic [1:0]            p;
    logic                  frame_end;

    assign cw = {1'b0, count_reg};
    assign c1 = cw + NP_BITS'(1);

    always_comb begin
        if (cw < bounds.b1) begin
            p  = 2'd0;
            ps = '0;
            pe = bounds.b1;
        end else if (cw < bounds.b2) begin
            p  = 2'd1;
            ps = bounds.b1;
            pe = bounds.b2;
        end else begin
            p  = 2'd2;
            ps = bounds.b2;
            pe = bounds.n;
        end
    end

    assign frame_end = (c1 >= bounds.n);

    always_comb begin
        item.sample        = sample;
        item.idx           = count_reg;
        item.rel           = INDEX_BITS'(cw - ps);
        item.plane         = p;
        item.frame_restart = (count_reg == '0);
        item.plane_restart = (cw == ps) || (p != plane_reg);
        item.frame_end     = frame_end;
        item.emit_plane    = bounds.rgb_mode && (frame_end || (c1 >= pe));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            plane_reg <= 2'd0;
        end else if (accept) begin
            if (frame_end) begin
                count_reg <= '0;
                plane_reg <= 2'd0;
            end else begin
                count_reg <= c1[INDEX_BITS-1:0];
                plane_reg <= p;
            end
        end
    end

endmodule

// ----- design/iml_queue.sv -----
// ----------------------------------------------------------------------------
// iml_queue: four-entry queue between front and back
// Lets the back stall on a full output while the front keeps taking samples.
// ----------------------------------------------------------------------------
module iml_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  iml_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output iml_pkg::item_t  head_item
);
    import iml_pkg::*;

    item_t      mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    assign full       = (count_reg == 3'd4);
    assign head_valid = (count_reg != 3'd0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            if (push && !pop)
                count_reg <= count_reg + 3'd1;
            else if (pop && !push)
                count_reg <= count_reg - 3'd1;
        end
    end

endmodule

// ----- design/iml_back.sv -----
// ----------------------------------------------------------------------------
// iml_back: extreme trackers and result output
// Updates the overall and per-plane min/max trackers and holds up to two
// pending results (plane first, overall second) for the output channel.
// ----------------------------------------------------------------------------
module iml_back (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    head_valid,
    input  iml_pkg::item_t                          head_item,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output iml_pkg::result_t                        m_result
);
    import iml_pkg::*;

    logic signed [SAMPLE_BITS-1:0] ov_min_reg, ov_max_reg, pl_min_reg, pl_max_reg;
    logic [INDEX_BITS-1:0]         ov_min_at_reg, ov_max_at_reg;
    logic [INDEX_BITS-1:0]         pl_min_at_reg, pl_max_at_reg;
    logic signed [SAMPLE_BITS-1:0] ov_min_next, ov_max_next, pl_min_next, pl_max_next;
    logic [INDEX_BITS-1:0]         ov_min_at_next, ov_max_at_next;
    logic [INDEX_BITS-1:0]         pl_min_at_next, pl_max_at_next;
    logic                          plane_v_reg, all_v_reg;
    result_t                       plane_res_reg, all_res_reg;
    logic                          out_free, needs_out, xfer;

    always_comb begin
        ov_min_next    = ov_min_reg;
        ov_min_at_next = ov_min_at_reg;
        ov_max_next    = ov_max_reg;
        ov_max_at_next = ov_max_at_reg;
        if (head_item.frame_restart) begin
            ov_min_next    = head_item.sample;
            ov_max_next    = head_item.sample;
            ov_min_at_next = '0;
            ov_max_at_next = '0;
        end else begin
            if (head_item.sample < ov_min_reg) begin
                ov_min_next    = head_item.sample;
                ov_min_at_next = head_item.idx;
            end
            if (head_item.sample > ov_max_reg) begin
                ov_max_next    = head_item.sample;
                ov_max_at_next = head_item.idx;
            end
        end
    end

    always_comb begin
        pl_min_next    = pl_min_reg;
        pl_min_at_next = pl_min_at_reg;
        pl_max_next    = pl_max_reg;
        pl_max_at_next = pl_max_at_reg;
        if (head_item.plane_restart) begin
            pl_min_next    = head_item.sample;
            pl_max_next    = head_item.sample;
            pl_min_at_next = '0;
            pl_max_at_next = '0;
        end else begin
            if (head_item.sample < pl_min_reg) begin
                pl_min_next    = head_item.sample;
                pl_min_at_next = head_item.rel;
            end
            if (head_item.sample > pl_max_reg) begin
                pl_max_next    = head_item.sample;
                pl_max_at_next = head_item.rel;
            end
        end
    end

    // output drains to empty this cycle, so a new pair may load
    assign out_free  = !(plane_v_reg || all_v_reg) ||
                       (m_tready && (plane_v_reg != all_v_reg));
    assign needs_out = head_item.emit_plane || head_item.frame_end;
    assign pop       = head_valid && (!needs_out || out_free);

    assign m_tvalid = plane_v_reg || all_v_reg;
    assign m_result = plane_v_reg ? plane_res_reg : all_res_reg;
    assign xfer     = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (pop) begin
            ov_min_reg    <= ov_min_next;
            ov_max_reg    <= ov_max_next;
            ov_min_at_reg <= ov_min_at_next;
            ov_max_at_reg <= ov_max_at_next;
            pl_min_reg    <= pl_min_next;
            pl_max_reg    <= pl_max_next;
            pl_min_at_reg <= pl_min_at_next;
            pl_max_at_reg <= pl_max_at_next;
        end
        if (pop && needs_out) begin
            plane_res_reg.kind      <= kind_t'(head_item.plane + 2'd1);
            plane_res_reg.min_value <= pl_min_next;
            plane_res_reg.max_value <= pl_max_next;
            plane_res_reg.min_index <= pl_min_at_next;
            plane_res_reg.max_index <= pl_max_at_next;
            plane_res_reg.last      <= 1'b0;
            all_res_reg.kind        <= KIND_OVERALL;
            all_res_reg.min_value   <= ov_min_next;
            all_res_reg.max_value   <= ov_max_next;
            all_res_reg.min_index   <= ov_min_at_next;
            all_res_reg.max_index   <= ov_max_at_next;
            all_res_reg.last        <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_v_reg <= 1'b0;
            all_v_reg   <= 1'b0;
        end else if (pop && needs_out) begin
            plane_v_reg <= head_item.emit_plane;
            all_v_reg   <= head_item.frame_end;
        end else if (xfer) begin
            // plane result leaves ahead of the overall one
            if (plane_v_reg)
                plane_v_reg <= 1'b0;
            else
                all_v_reg <= 1'b0;
        end
    end

endmodule

// ----- design/image_min_max_locator.sv -----
// ----------------------------------------------------------------------------
// image_min_max_locator: running min/max with first-occurrence indices
// Tracks overall and per-colour-plane extremes over a raster frame.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction carries
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | one sample (tdata)
//  m_       | out       | one result: extremes (tdata), kind (tuser), tlast
//  cfg_     | in        | register write: index, data
//
// One sample is taken per cycle; the input stalls when the queue is full or the
// configuration is busy. A sample that closes a plane or the frame waits in the
// four-entry queue until the output holds no earlier result; two results leave
// one per cycle while m_tready is high. After reset and after each configuration
// write s_tready stays low while the plane boundaries are recomputed by the
// divide-by-three multiplier. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module image_min_max_locator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [iml_pkg::SAMPLE_BITS-1:0]       s_tdata,   // [31:0] sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] min_value, [63:32] max_value, [87:64] min_index, [111:88] max_index
    output logic [iml_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    output logic [iml_pkg::KIND_BITS-1:0]         m_tuser,   // [1:0] kind
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [iml_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [iml_pkg::NP_BITS-1:0]           cfg_data
);
    import iml_pkg::*;

    bounds_t bounds;
    logic    cfg_busy;
    logic    accept;
    item_t   front_item;
    item_t   head_item;
    logic    q_full, q_pop, q_valid;
    result_t result;

    assign s_tready = !q_full && !cfg_busy;
    assign accept   = s_tvalid && s_tready;

    iml_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds),
        .busy      (cfg_busy)
    );

    iml_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .bounds  (bounds),
        .accept  (accept),
        .sample  ($signed(s_tdata)),
        .item    (front_item)
    );

    iml_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    iml_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    assign m_tdata = {result.max_index, result.min_index,
                      result.max_value, result.min_value};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

endmodule

// ----- design/iml_checker.sv -----
// ----------------------------------------------------------------------------
// iml_checker: port-level checks for the image min/max locator
// Watches the top level's channels and flags illegal result sequences and input taken during a boundary update.
// ----------------------------------------------------------------------------
module iml_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [iml_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input logic [iml_pkg::KIND_BITS-1:0]     m_tuser,
    input logic                              m_tlast,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);
    import iml_pkg::*;

    // the frame result is the only one with tlast and it is always overall
    a_last_is_overall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_OVERALL)))
        else $error("tlast does not match result kind");

    // input held off while boundaries are recomputed
    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_tready ##1 !s_tready)
        else $error("sample accepted during boundary update");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind image_min_max_locator iml_checker u_iml_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ----- sim/image_min_max_locator_test.sv -----
// ----------------------------------------------------------------------------
// image_min_max_locator_test: self-checking bench for the min/max locator
// Streams samples into the block under several frame lengths and colour
// settings, predicts every plane and frame result in step with the accepted
// samples, and checks each returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module image_min_max_locator_test;
    import iml_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 8;     // front, queue and back stages
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 450;

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EDGE} value_mix_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [SAMPLE_BITS-1:0]     s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]   m_tdata;
    logic [KIND_BITS-1:0]       m_tuser;
    logic                       m_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [NP_BITS-1:0]         cfg_data  = '0;

    image_min_max_locator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [SAMPLE_BITS-1:0] pending_samples[$];
    result_t                expected_results[$];
    int                     errors     = 0;
    int                     sent_items = 0;
    int                     send_idle  = 21;
    int                     recv_idle  = 54;
    logic                   pressure_on = 1'b0;

    // shadow of the block's registers and tracking state
    logic [NP_BITS-1:0]            frame_points = NP_BITS'(1);
    logic                          color_mode   = 1'b0;
    logic [INDEX_BITS-1:0]         frame_pos    = '0;
    logic [1:0]                    held_plane   = '0;
    logic signed [SAMPLE_BITS-1:0] frame_lo = '0, frame_hi = '0, plane_lo = '0, plane_hi = '0;
    logic [INDEX_BITS-1:0]         frame_lo_at = '0, frame_hi_at = '0;
    logic [INDEX_BITS-1:0]         plane_lo_at = '0, plane_hi_at = '0;

    function automatic void track_sample(input logic signed [SAMPLE_BITS-1:0] s);
        logic [NP_BITS-1:0]    n, b1, b2, ps, pe;
        logic [1:0]            p;
        logic [INDEX_BITS-1:0] c, rel;
        logic                  frame_end, plane_end;
        result_t               r;
        n = frame_points;
        if (n == 0) n = NP_BITS'(1);
        if (n > NP_MAX) n = NP_MAX;
        b1 = NP_BITS'(n / 32'd3);
        b2 = NP_BITS'((32'(n) * 32'd2) / 32'd3);
        c = frame_pos;
        if (c < b1) begin
            p = 2'd0; ps = '0; pe = b1;
        end else if (c < b2) begin
            p = 2'd1; ps = b1; pe = b2;
        end else begin
            p = 2'd2; ps = b2; pe = n;
        end
        if (c == 0) begin
            frame_lo = s; frame_hi = s; frame_lo_at = '0; frame_hi_at = '0;
        end else begin
            if (s > frame_hi) begin frame_hi = s; frame_hi_at = c; end
            if (s < frame_lo) begin frame_lo = s; frame_lo_at = c; end
        end
        rel = c - ps[INDEX_BITS-1:0];
        // a plane switch not at its boundary (config change) also restarts it
        if (NP_BITS'(c) == ps || p != held_plane) begin
            plane_lo = s; plane_hi = s; plane_lo_at = '0; plane_hi_at = '0;
        end else begin
            if (s > plane_hi) begin plane_hi = s; plane_hi_at = rel; end
            if (s < plane_lo) begin plane_lo = s; plane_lo_at = rel; end
        end
        held_plane = p;
        frame_end = (NP_BITS'(c) + NP_BITS'(1)) >= n;
        plane_end = frame_end || (NP_BITS'(c) + NP_BITS'(1)) >= pe;
        if (color_mode && plane_end) begin
            r.kind      = kind_t'(p + 2'd1);
            r.min_value = plane_lo;
            r.max_value = plane_hi;
            r.min_index = plane_lo_at;
            r.max_index = plane_hi_at;
            r.last      = 1'b0;
            expected_results.push_back(r);
        end
        if (frame_end) begin
            r.kind      = KIND_OVERALL;
            r.min_value = frame_lo;
            r.max_value = frame_hi;
            r.min_index = frame_lo_at;
            r.max_index = frame_hi_at;
            r.last      = 1'b1;
            expected_results.push_back(r);
            frame_pos  = '0;
            held_plane = '0;
        end else begin
            frame_pos = c + 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // sample driver
    always @(posedge aclk) begin
        logic accepted;
        accepted = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (accepted) begin
                track_sample(pending_samples.pop_front());
            end
            if (!s_tvalid || accepted) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls plus one long hold-off
    int   hold_count = 0;
    logic hold_done  = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (pressure_on && !hold_done) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d tdata %0h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_tuser));
                check_field("min_value", 64'($unsigned(want.min_value)),
                            64'(m_tdata[31:0]));
                check_field("max_value", 64'($unsigned(want.max_value)),
                            64'(m_tdata[63:32]));
                check_field("min_index", 64'(want.min_index), 64'(m_tdata[87:64]));
                check_field("max_index", 64'(want.max_index), 64'(m_tdata[111:88]));
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("image_min_max_locator_test failed");
            $finish;
        end
    end

    // write both registers back to back, valid held high across the pair
    task automatic configure(input logic [NP_BITS-1:0] points, input logic color);
        cfg_valid <= 1'b1;
        cfg_index <= REG_NUM_POINTS;
        cfg_data  <= points;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        frame_points = points;
        cfg_index <= REG_RGB_MODE;
        cfg_data  <= NP_BITS'(color);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        color_mode = color;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] v);
        pending_samples.push_back(v);
        sent_items++;
    endtask

    // wait until every sample is taken and every result is back, then settle
    task automatic drain();
        while (pending_samples.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input value_mix_t mix);
        case (mix)
            VAL_NARROW: return SAMPLE_BITS'($urandom_range(4)) - SAMPLE_BITS'(2);
            VAL_EDGE: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [NP_BITS-1:0] points;
        logic               color;
        int                 count;
        value_mix_t         mix;
        logic               pressure_started;
        pressure_started = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-sample frames at the value extremes
        configure(NP_BITS'(1), 1'b0);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h8000_0000);
        queue_sample(32'h0000_0000);
        queue_sample(32'hFFFF_FFFF);
        drain();
        // zero length acts as one; colour puts the lone sample in blue
        configure('0, 1'b1);
        queue_sample(32'h0001_0000);
        queue_sample(32'hFFFF_0000);
        drain();
        // two samples in colour: red plane is empty
        configure(NP_BITS'(2), 1'b1);
        queue_sample(32'd5);
        queue_sample(32'd5);
        drain();
        // ties keep the first index, in the red plane and across the frame
        configure(NP_BITS'(6), 1'b1);
        queue_sample(32'd3);
        queue_sample(32'd3);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'd7);
        queue_sample(32'd7);
        queue_sample(32'hFFFF_FFFF);
        drain();
        // oversized length saturates; frame stays open
        configure(25'h1FF_FFFF, 1'b0);
        queue_sample(32'd10);
        queue_sample(32'h8000_0001);
        queue_sample(32'h7FFF_FFFE);
        drain();
        // shrink mid-frame: next sample closes the frame in a new plane
        configure(NP_BITS'(4), 1'b1);
        queue_sample(32'd1);
        queue_sample(32'd2);
        queue_sample(32'd0);
        drain();
        configure(NP_BITS'(5), 1'b0);
        queue_sample(32'd9);
        queue_sample(32'd9);
        queue_sample(32'hFFFF_FFF0);
        drain();

        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items < 170) begin
                send_idle = 21; recv_idle = 54;
            end else if (sent_items < 320) begin
                send_idle = 54; recv_idle = 21;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            if (sent_items >= 320 && !pressure_started) begin
                // every sample closes a plane: the sample queue fills while the output is held
                pressure_started = 1'b1;
                pressure_on <= 1'b1;
                configure(NP_BITS'(3), 1'b1);
                repeat (40) queue_sample(pick_sample(VAL_FULL));
                drain();
            end else begin
                if ($urandom_range(99) < 6) begin
                    case ($urandom_range(3))
                        0: points = '0;
                        1: points = NP_MAX;
                        2: points = NP_MAX + 1'b1;
                        default: points = NP_BITS'($urandom) | NP_MAX;
                    endcase
                    count = $urandom_range(1, 8);
                end else begin
                    points = ($urandom_range(99) < 70) ? NP_BITS'($urandom_range(1, 12))
                                                       : NP_BITS'($urandom_range(13, 50));
                    // mostly whole frames, sometimes a partial one
                    count = ($urandom_range(3) == 0) ? $urandom_range(1, 32'(points))
                                                     : 32'(points) * $urandom_range(1, 2);
                end
                color = 1'($urandom_range(1));
                mix = value_mix_t'($urandom_range(2));
                configure(points, color);
                repeat (count) queue_sample(pick_sample(mix));
                drain();
            end
        end

        drain();
        if (errors == 0) begin
            $display("image_min_max_locator_test passed");
        end else begin
            $display("image_min_max_locator_test failed");
        end
        $finish;
    end

endmodule
